// ===== rtl/core/pkhs_pkg.sv =====
// ----------------------------------------------------------------------------
// pkhs_pkg
// Shared codes for the pair key chained hash set core.
// ----------------------------------------------------------------------------
package pkhs_pkg;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic REG_BUCKET_COUNT = 1'b0;
    localparam logic REG_ENTRY_LIMIT  = 1'b1;

    localparam int BUCKET_CFG_W = 11;
    localparam int LIMIT_CFG_W  = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int KEY_W        = 32;
    localparam int INDEX_OUT_W  = 12;

    // start / done handshake between sequencer and remainder unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
    } pkhs_mod_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] remainder;
    } pkhs_mod_rsp_t;

endpackage

// ===== rtl/core/pkhs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// pkhs_mod_unit
// Restoring bit-serial remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pkhs_mod_unit import pkhs_pkg::*; #(
    parameter int DIV_W = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pkhs_mod_req_t       req,
    input  logic [DIV_W-1:0]    divisor,
    output pkhs_mod_rsp_t       rsp
);

    logic [31:0]    quo_reg, quo_next;
    logic [DIV_W:0] rem_reg, rem_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DIV_W:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DIV_W-1:0], quo_reg[31]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = 32'(rem_reg[DIV_W-1:0]);

endmodule

// ===== rtl/core/pair_key_chained_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// pair_key_chained_hash_set_core
// Chained hash set of signed 32-bit key pairs with lookup and insert.
// ----------------------------------------------------------------------------
// One transaction at a time. A request passes through the bucket hash (a
// bit-serial remainder unit plus its done flag), the bucket head read, a
// decide step, the presentation of the result and the return to idle. Each
// chain entry visited adds an entry memory read, a compare and a decide step;
// a hit in the compare goes straight to the result. An inserted entry is
// written in the decide cycle. A stalled result holds the block for as long
// as m_ready stays low. After reset a clearing pass over all MAX_BUCKETS
// entries empties the bucket head memory; no request is taken during it.
module pair_key_chained_hash_set_core import pkhs_pkg::*; #(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic signed [KEY_W-1:0] s_key_first,
    input  logic signed [KEY_W-1:0] s_key_second,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [INDEX_OUT_W-1:0]  m_entry_index
);

    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int DW  = $clog2(MAX_BUCKETS + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_HEAD   = 4'd3;
    localparam logic [3:0] S_HEADW  = 4'd4;
    localparam logic [3:0] S_READ   = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // configuration
    logic [BUCKET_CFG_W-1:0] bcount_reg;
    logic [LIMIT_CFG_W-1:0]  limit_reg;
    logic [DW-1:0]           eff_buckets;
    logic [CW-1:0]           eff_limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcount_reg <= BUCKET_CFG_W'(1024);
            limit_reg  <= LIMIT_CFG_W'(4096);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BUCKET_COUNT: bcount_reg <= cfg_data[BUCKET_CFG_W-1:0];
                REG_ENTRY_LIMIT:  limit_reg  <= cfg_data[LIMIT_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (bcount_reg == '0) begin
            eff_buckets = DW'(1);
        end else if (32'(bcount_reg) > MAX_BUCKETS) begin
            eff_buckets = DW'(MAX_BUCKETS);
        end else begin
            eff_buckets = DW'(bcount_reg);
        end
        if (32'(limit_reg) > MAX_ENTRIES) begin
            eff_limit = CW'(MAX_ENTRIES);
        end else begin
            eff_limit = CW'(limit_reg);
        end
    end

    // memories: head has valid bit on top, link likewise
    logic [EW:0]      head_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] k1_mem   [MAX_ENTRIES];
    logic [KEY_W-1:0] k2_mem   [MAX_ENTRIES];
    logic [EW:0]      link_mem [MAX_ENTRIES];

    logic [3:0]         state_reg, state_next;
    logic [BW-1:0]      clr_reg;
    logic               op_reg;
    logic [KEY_W-1:0]   k1_reg, k2_reg;
    logic [BW-1:0]      bucket_reg;
    logic [EW:0]        head_rd_reg;
    logic [EW:0]        cur_reg;
    logic [KEY_W-1:0]   ek1_rd_reg, ek2_rd_reg;
    logic [EW:0]        link_rd_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      steps_reg;
    logic [1:0]         status_reg;
    logic [INDEX_OUT_W-1:0] index_reg;

    pkhs_mod_req_t mreq;
    pkhs_mod_rsp_t mrsp;
    logic [KEY_W-1:0] mag;

    assign mag           = s_key_first[KEY_W-1] ? (KEY_W'(0) - KEY_W'(s_key_first))
                                                : KEY_W'(s_key_first);
    assign mreq.start    = (state_reg == S_IDLE) && s_valid;
    assign mreq.dividend = mag;

    pkhs_mod_unit #(.DIV_W(DW)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .divisor (eff_buckets),
        .rsp     (mrsp)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_status      = status_reg;
    assign m_entry_index = index_reg;

    logic hit;
    assign hit = (ek1_rd_reg == k1_reg) && (ek2_rd_reg == k2_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == BW'(MAX_BUCKETS - 1)) state_next = S_IDLE;
            S_IDLE:   if (s_valid) state_next = S_HASH;
            S_HASH:   if (mrsp.done) state_next = S_HEAD;
            S_HEAD:   state_next = S_HEADW;
            S_HEADW:  state_next = S_DECIDE;
            S_READ:   state_next = S_CMP;
            S_CMP:    state_next = hit ? S_OUT : S_DECIDE;
            S_DECIDE: begin
                if (cur_reg[EW] && steps_reg < CW'(MAX_ENTRIES)) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT:    if (m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (state_reg == S_DECIDE && state_next == S_OUT && op_reg == OP_INSERT
                && count_reg < eff_limit) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // head memory port
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            head_mem[clr_reg] <= '0;
        end else if (state_reg == S_DECIDE && state_next == S_OUT
                     && op_reg == OP_INSERT && count_reg < eff_limit) begin
            head_mem[bucket_reg] <= {1'b1, count_reg[EW-1:0]};
        end
        head_rd_reg <= head_mem[bucket_reg];
    end

    // entry memories
    always_ff @(posedge aclk) begin
        if (state_reg == S_DECIDE && state_next == S_OUT
            && op_reg == OP_INSERT && count_reg < eff_limit) begin
            k1_mem[count_reg[EW-1:0]]   <= k1_reg;
            k2_mem[count_reg[EW-1:0]]   <= k2_reg;
            link_mem[count_reg[EW-1:0]] <= head_rd_reg;
        end
        ek1_rd_reg  <= k1_mem[cur_reg[EW-1:0]];
        ek2_rd_reg  <= k2_mem[cur_reg[EW-1:0]];
        link_rd_reg <= link_mem[cur_reg[EW-1:0]];
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg <= s_operation;
                k1_reg <= KEY_W'(s_key_first);
                k2_reg <= KEY_W'(s_key_second);
            end
            S_HASH: bucket_reg <= BW'(mrsp.remainder);
            S_HEADW: begin
                cur_reg   <= head_rd_reg;
                steps_reg <= '0;
            end
            S_CMP: begin
                if (hit) begin
                    status_reg <= ST_FOUND;
                    index_reg  <= INDEX_OUT_W'(cur_reg[EW-1:0]);
                end
                cur_reg   <= link_rd_reg;
                steps_reg <= steps_reg + CW'(1);
            end
            S_DECIDE: begin
                if (op_reg == OP_LOOKUP) begin
                    status_reg <= ST_MISSING;
                    index_reg  <= '0;
                end else if (count_reg >= eff_limit) begin
                    status_reg <= ST_FULL;
                    index_reg  <= '0;
                end else begin
                    status_reg <= ST_INSERTED;
                    index_reg  <= INDEX_OUT_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/pkhs_checker.sv =====
// ----------------------------------------------------------------------------
// pkhs_checker
// Port-level checks for the hash set core, bound to the top level.
// ----------------------------------------------------------------------------
module pkhs_checker import pkhs_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [1:0]             m_status,
    input logic [INDEX_OUT_W-1:0] m_entry_index
);

    // one transaction in flight: no new request while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");

    a_zero_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_MISSING || m_status == ST_FULL)
        |-> m_entry_index == '0) else $error("index not zero");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)) else $error("result dropped");

endmodule

bind pair_key_chained_hash_set_core pkhs_checker u_pkhs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_index (m_entry_index)
);

// ===== verif/pair_key_chained_hash_set_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_key_chained_hash_set_core_tb
// Drives lookups and inserts of key pairs through the chained hash set core,
// mirrors the set in a scoreboard model and compares every response in order.
// ----------------------------------------------------------------------------
module pair_key_chained_hash_set_core_tb;
    import pkhs_pkg::*;

    localparam int NBKT = 1024;
    localparam int NENT = 4096;
    localparam int STALL_LIMIT = 200000;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic                    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_operation;
    logic signed [KEY_W-1:0] s_key_first;
    logic signed [KEY_W-1:0] s_key_second;
    logic                    m_valid;
    logic                    m_ready;
    logic [1:0]              m_status;
    logic [INDEX_OUT_W-1:0]  m_entry_index;

    pair_key_chained_hash_set_core dut (.*);

    typedef struct {
        logic [1:0]             status;
        logic [INDEX_OUT_W-1:0] index;
    } lookup_result_t;

    // scoreboard copy of the set
    logic [31:0] set_key_first[NENT];
    logic [31:0] set_key_second[NENT];
    int          set_next[NENT];
    int          set_head[NBKT];
    int          set_count;
    int          model_buckets;
    int          model_limit;

    lookup_result_t expected_q[$];
    int  error_count;
    int  idle_cycles;
    bit  hold_off;
    bit  track_keys;
    logic [31:0] used_first[$];
    logic [31:0] used_second[$];

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    function automatic lookup_result_t predict_set_access(logic op, logic [31:0] k1,
                                                          logic [31:0] k2);
        lookup_result_t r;
        logic [31:0] mag;
        int nb;
        int lim;
        int h;
        int n;
        nb = (model_buckets == 0) ? 1 : (model_buckets > NBKT ? NBKT : model_buckets);
        lim = (model_limit > NENT) ? NENT : model_limit;
        mag = k1[31] ? (32'd0 - k1) : k1;
        h = int'(mag % nb);
        n = set_head[h];
        while (n >= 0) begin
            if (set_key_first[n] == k1 && set_key_second[n] == k2) begin
                r.status = ST_FOUND;
                r.index = n[INDEX_OUT_W-1:0];
                return r;
            end
            n = set_next[n];
        end
        r.index = '0;
        if (op == OP_LOOKUP) begin
            r.status = ST_MISSING;
        end else if (set_count >= lim) begin
            r.status = ST_FULL;
        end else begin
            n = set_count;
            set_key_first[n] = k1;
            set_key_second[n] = k2;
            set_next[n] = set_head[h];
            set_head[h] = n;
            set_count = n + 1;
            r.status = ST_INSERTED;
            r.index = n[INDEX_OUT_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_pair(logic op, logic [31:0] k1, logic [31:0] k2);
        s_valid <= 1'b1;
        s_operation <= op;
        s_key_first <= k1;
        s_key_second <= k2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_set_access(op, k1, k2));
        if (track_keys) begin
            used_first.push_back(k1);
            used_second.push_back(k2);
        end
        s_valid <= 1'b0;
        // a wait follows so valid is not driven twice in one step
        repeat (short_gap() + 1) @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int value);
        // registers change only with no transaction in flight
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BUCKET_COUNT) model_buckets = value & 32'h7ff;
        else model_limit = value & 32'h1fff;
    endtask

    // response checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_status, -1);
            end else begin
                lookup_result_t e;
                e = expected_q.pop_front();
                if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                if (m_entry_index !== e.index)
                    report_mismatch("entry_index", m_entry_index, e.index);
            end
        end
    end

    // receiver stalls
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 30) : 1) @(posedge aclk);
            m_ready <= 1'b0;
            repeat (short_gap() + 1) @(posedge aclk);
        end
    end

    // watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_extremes();
        logic [31:0] vals[6];
        vals = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'd1024};
        foreach (vals[i]) send_pair(OP_LOOKUP, vals[i], vals[i]);
        foreach (vals[i]) send_pair(OP_INSERT, vals[i], ~vals[i]);
        foreach (vals[i]) send_pair(OP_LOOKUP, vals[i], ~vals[i]);
        send_pair(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        send_pair(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        drain();
    endtask

    task automatic test_small_modulus();
        write_reg(REG_BUCKET_COUNT, 0);
        for (int i = 0; i < 8; i++) send_pair(OP_INSERT, $urandom_range(0, 20), i);
        write_reg(REG_BUCKET_COUNT, 3);
        for (int i = 0; i < 8; i++) send_pair(1'($urandom_range(0, 1)), $urandom_range(0, 20), i);
        write_reg(REG_BUCKET_COUNT, 2047);
        drain();
    endtask

    task automatic test_pool_full();
        write_reg(REG_ENTRY_LIMIT, 0);
        send_pair(OP_INSERT, 32'd77, 32'd78);
        write_reg(REG_ENTRY_LIMIT, 8191);
        drain();
    endtask

    task automatic test_random(int count, int nb, int lim);
        logic [31:0] k1;
        logic [31:0] k2;
        int pick;
        drain();
        write_reg(REG_BUCKET_COUNT, nb);
        write_reg(REG_ENTRY_LIMIT, lim);
        for (int i = 0; i < count; i++) begin
            if (used_first.size() != 0 && $urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, used_first.size() - 1);
                k1 = used_first[pick];
                k2 = used_second[pick];
                if ($urandom_range(0, 3) == 0) k2 ^= 32'd1 << $urandom_range(0, 31);
            end else begin
                k1 = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 64) - 32;
                k2 = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3);
            end
            if (i == count / 3) hold_off = 1'b1;
            send_pair($urandom_range(0, 2) != 0, k1, k2);
        end
        drain();
    endtask

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = REG_BUCKET_COUNT;
        cfg_data = '0;
        s_valid = 1'b0;
        s_operation = OP_LOOKUP;
        s_key_first = '0;
        s_key_second = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        track_keys = 1'b1;
        set_count = 0;
        model_buckets = 1024;
        model_limit = 4096;
        foreach (set_head[i]) set_head[i] = -1;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_small_modulus();
        test_pool_full();
        test_random(250, 7, 4096);
        test_random(200, 1024, 600);
        test_random(200, 33, 5000);
        repeat (50) @(posedge aclk);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
